[sv/lbbc_pkg.sv]
// ----------------------------------------------------------------------------
// lbbc_pkg
// Shared constants and types for the LED blink and breathe controller.
// ----------------------------------------------------------------------------
package lbbc_pkg;

  // Field and register widths
  localparam int unsigned INTERVAL_W = 16;
  localparam int unsigned PULSE_W    = 20;
  localparam int unsigned DEBOUNCE_W = 10;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned S_TDATA_W  = 8;
  localparam int unsigned M_TDATA_W  = 24;

  // Default sizes of the internal timers and of the pulse width register
  localparam int unsigned TIMER_BITS_DEF = 16;
  localparam int unsigned PULSE_BITS_DEF = 20;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_INTERVAL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_INTERVAL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LOW     = 3'd5;

  // Register reset values
  localparam logic [INTERVAL_W-1:0] BLINK_INTERVAL_RST = 16'd500;
  localparam logic [INTERVAL_W-1:0] STEP_INTERVAL_RST  = 16'd20;
  localparam logic [PULSE_W-1:0]    PWM_PERIOD_RST     = 20'd20000;
  localparam logic [PULSE_W-1:0]    STEP_SIZE_RST      = 20'd1000;
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST       = 10'd50;

  // Saturation limit of the time since the last accepted level change
  localparam logic [DEBOUNCE_W-1:0] SINCE_MAX = {DEBOUNCE_W{1'b1}};

  // Mode event handed from the debouncer to the pattern generator
  typedef struct packed {
    logic switched;   // this request toggled the mode
    logic ramp_mode;  // mode after this request
  } mode_evt_t;

endpackage

[sv/led_blink_breathe_controller_unit.sv]
// ----------------------------------------------------------------------------
// led_blink_breathe_controller_unit
// Debounced button toggles between LED blinking and a PWM breathing ramp.
// ----------------------------------------------------------------------------
// Port group  Direction  Contents
// s_axis      in         one millisecond tick: button_raw
// m_axis      out        one result per tick: led, pulse width, mode, switch flag
// cfg         in         register writes, no read-back
//
// Each request passes from input to output through an input register and
// a result register with the state update in between. A new request can be
// accepted every cycle; the result register frees as it is taken, so the
// input only stalls when both registers are full and m_axis_tready is low.
// rst is synchronous and restores all control state and register defaults.
// ----------------------------------------------------------------------------
module led_blink_breathe_controller_unit
  import lbbc_pkg::*;
#(
  parameter int unsigned TIMER_BITS = TIMER_BITS_DEF,
  parameter int unsigned PULSE_BITS = PULSE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // [0] button_raw, [7:1] zero
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [M_TDATA_W-1:0]  m_axis_tdata,   // [0] led_level, [20:1] pulse_width,
                                                // [21] ramp_mode, [22] mode_changed,
                                                // [23] zero
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers
  logic [INTERVAL_W-1:0] blink_interval_ms;
  logic [INTERVAL_W-1:0] step_interval_ms;
  logic [PULSE_W-1:0]    pwm_period;
  logic [PULSE_W-1:0]    step_size;
  logic [DEBOUNCE_W-1:0] debounce_ms;
  logic                  button_active_low;

  // Input and result registers
  logic                  in_valid;
  logic                  in_button;
  logic                  out_valid;
  logic                  out_led;
  logic [PULSE_W-1:0]    out_width;
  logic                  out_ramp;
  logic                  out_changed;

  logic                  advance;
  mode_evt_t             evt;
  logic                  led_next;
  logic [PULSE_W-1:0]    width_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      blink_interval_ms <= BLINK_INTERVAL_RST;
      step_interval_ms  <= STEP_INTERVAL_RST;
      pwm_period        <= PWM_PERIOD_RST;
      step_size         <= STEP_SIZE_RST;
      debounce_ms       <= DEBOUNCE_RST;
      button_active_low <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BLINK_INTERVAL: blink_interval_ms <= cfg_data[INTERVAL_W-1:0];
        REG_STEP_INTERVAL:  step_interval_ms  <= cfg_data[INTERVAL_W-1:0];
        REG_PWM_PERIOD:     pwm_period        <= cfg_data[PULSE_W-1:0];
        REG_STEP_SIZE:      step_size         <= cfg_data[PULSE_W-1:0];
        REG_DEBOUNCE:       debounce_ms       <= cfg_data[DEBOUNCE_W-1:0];
        REG_ACTIVE_LOW:     button_active_low <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The held request moves into the result register whenever that is free
  // or being emptied in the same cycle.
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_button <= s_axis_tdata[0];
    end
  end

  lbbc_debounce u_debounce (
    .clk               (clk),
    .rst               (rst),
    .advance           (advance),
    .button_raw        (in_button),
    .button_active_low (button_active_low),
    .debounce_ms       (debounce_ms),
    .evt               (evt)
  );

  lbbc_pattern #(
    .TIMER_BITS (TIMER_BITS),
    .PULSE_BITS (PULSE_BITS)
  ) u_pattern (
    .clk               (clk),
    .rst               (rst),
    .advance           (advance),
    .evt               (evt),
    .blink_interval_ms (blink_interval_ms),
    .step_interval_ms  (step_interval_ms),
    .pwm_period        (pwm_period),
    .step_size         (step_size),
    .led_next          (led_next),
    .width_next        (width_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_led     <= led_next;
      out_width   <= width_next;
      out_ramp    <= evt.ramp_mode;
      out_changed <= evt.switched;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_changed, out_ramp, out_width, out_led};

endmodule

[sv/lbbc_debounce.sv]
// ----------------------------------------------------------------------------
// lbbc_debounce
// Button debouncer and mode toggle; state advances on each request.
// ----------------------------------------------------------------------------
module lbbc_debounce
  import lbbc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  logic                  button_raw,
  input  logic                  button_active_low,
  input  logic [DEBOUNCE_W-1:0] debounce_ms,
  output mode_evt_t             evt
);

  logic                  stable_level, stable_level_next;
  logic [DEBOUNCE_W-1:0] since_change, since_change_next;
  logic                  in_ramp_mode, in_ramp_mode_next;
  logic                  level;
  logic [DEBOUNCE_W-1:0] elapsed;
  logic                  take;

  always_comb begin
    level   = button_raw ^ button_active_low;
    elapsed = (since_change == SINCE_MAX) ? SINCE_MAX : since_change + 1'b1;
    take    = (level != stable_level) && (elapsed >= debounce_ms);

    stable_level_next = stable_level;
    since_change_next = elapsed;
    in_ramp_mode_next = in_ramp_mode;
    evt.switched      = 1'b0;
    if (take) begin
      stable_level_next = level;
      since_change_next = '0;
      // Only the change to the pressed level counts as a press.
      if (level) begin
        evt.switched      = 1'b1;
        in_ramp_mode_next = ~in_ramp_mode;
      end
    end
    evt.ramp_mode = in_ramp_mode_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stable_level <= 1'b0;
      since_change <= '0;
      in_ramp_mode <= 1'b0;
    end else if (advance) begin
      stable_level <= stable_level_next;
      since_change <= since_change_next;
      in_ramp_mode <= in_ramp_mode_next;
    end
  end

endmodule

[sv/lbbc_pattern.sv]
// ----------------------------------------------------------------------------
// lbbc_pattern
// Blink timer and triangular pulse width ramp, one step per request.
// ----------------------------------------------------------------------------
module lbbc_pattern
  import lbbc_pkg::*;
#(
  parameter int unsigned TIMER_BITS = TIMER_BITS_DEF,
  parameter int unsigned PULSE_BITS = PULSE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  mode_evt_t             evt,
  input  logic [INTERVAL_W-1:0] blink_interval_ms,
  input  logic [INTERVAL_W-1:0] step_interval_ms,
  input  logic [PULSE_W-1:0]    pwm_period,
  input  logic [PULSE_W-1:0]    step_size,
  output logic                  led_next,
  output logic [PULSE_W-1:0]    width_next
);

  localparam int unsigned CW = (TIMER_BITS > INTERVAL_W) ? TIMER_BITS : INTERVAL_W;
  localparam int unsigned PW = ((PULSE_BITS > PULSE_W) ? PULSE_BITS : PULSE_W) + 1;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};
  localparam logic [PW-1:0]         PULSE_MAX = PW'({PULSE_BITS{1'b1}});

  logic [TIMER_BITS-1:0] blink_count, blink_count_next;
  logic [TIMER_BITS-1:0] ramp_count, ramp_count_next;
  logic                  blink_phase, blink_phase_next;
  logic                  led_pin;
  logic [PULSE_BITS-1:0] width_now, width_now_next;
  logic                  falling, falling_next;

  logic [TIMER_BITS-1:0] blink_inc, ramp_inc;
  logic                  blink_fire, ramp_fire;
  logic [PW-1:0]         w_ext, step_ext, period_ext, p_raw, p_clamp;
  logic                  turn;

  always_comb begin
    // Saturating interval timers; an interval of zero fires every tick.
    blink_inc  = (blink_count == TIMER_MAX) ? blink_count : blink_count + 1'b1;
    ramp_inc   = (ramp_count == TIMER_MAX) ? ramp_count : ramp_count + 1'b1;
    blink_fire = CW'(blink_inc) >= CW'(blink_interval_ms);
    ramp_fire  = CW'(ramp_inc) >= CW'(step_interval_ms);

    // Ramp step, with the downward step clamped at zero.
    w_ext      = PW'(width_now);
    step_ext   = PW'(step_size);
    period_ext = PW'(pwm_period);
    if (falling) begin
      p_raw = (w_ext > step_ext) ? w_ext - step_ext : '0;
    end else begin
      p_raw = w_ext + step_ext;
    end
    turn    = (p_raw >= period_ext) || (p_raw == '0);
    p_clamp = (p_raw > period_ext) ? period_ext : p_raw;
    if (p_clamp > PULSE_MAX) begin
      p_clamp = PULSE_MAX;
    end

    blink_count_next = blink_count;
    ramp_count_next  = ramp_count;
    blink_phase_next = blink_phase;
    led_next         = led_pin;
    width_now_next   = width_now;
    falling_next     = falling;

    if (evt.switched) begin
      led_next = 1'b0;
      if (evt.ramp_mode) begin
        width_now_next  = '0;
        falling_next    = 1'b0;
        ramp_count_next = '0;
      end else begin
        blink_count_next = '0;
      end
    end else if (evt.ramp_mode) begin
      ramp_count_next = ramp_fire ? '0 : ramp_inc;
      if (ramp_fire) begin
        width_now_next = p_clamp[PULSE_BITS-1:0];
        falling_next   = falling ^ turn;
      end
    end else begin
      blink_count_next = blink_fire ? '0 : blink_inc;
      if (blink_fire) begin
        blink_phase_next = ~blink_phase;
        led_next         = ~blink_phase;
      end
    end

    // The PWM is off in blink mode.
    width_next = evt.ramp_mode ? PULSE_W'(PW'(width_now_next)) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blink_count <= '0;
      ramp_count  <= '0;
      blink_phase <= 1'b0;
      led_pin     <= 1'b0;
      width_now   <= '0;
      falling     <= 1'b0;
    end else if (advance) begin
      blink_count <= blink_count_next;
      ramp_count  <= ramp_count_next;
      blink_phase <= blink_phase_next;
      led_pin     <= led_next;
      width_now   <= width_now_next;
      falling     <= falling_next;
    end
  end

endmodule

[verif/led_blink_breathe_controller_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_blink_breathe_controller_unit_test
// Self-checking bench for the debounced blink and breathing LED controller.
// Button samples go in on s_axis, one per tick, and a model of the debounce,
// mode toggle, blink timer and triangle ramp predicts the result of every
// tick. The run steps through several register settings, extremes among them,
// with random idling on the input side and stalls on the output side.
// ----------------------------------------------------------------------------
module led_blink_breathe_controller_unit_test;
  import lbbc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;

  // Indexes past the last register; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic               mode_changed;
    logic               ramp_mode;
    logic [PULSE_W-1:0] pulse_width;
    logic               led_level;
  } tick_result_t;

  typedef struct {
    int unsigned blink_iv;
    int unsigned step_iv;
    int unsigned period;
    int unsigned step_sz;
    int unsigned debounce;
    bit          act_low;
    int          n_ticks;
  } phase_cfg_t;

  class led_blink_scoreboard;
    logic [INTERVAL_W-1:0] blink_iv;
    logic [INTERVAL_W-1:0] step_iv;
    logic [PULSE_W-1:0]    period;
    logic [PULSE_W-1:0]    step_sz;
    logic [DEBOUNCE_W-1:0] debounce;
    logic                  act_low;

    logic                  ramp_on;
    logic                  stable;
    logic [DEBOUNCE_W-1:0] since;
    logic [INTERVAL_W-1:0] blink_cnt;
    logic [INTERVAL_W-1:0] ramp_cnt;
    logic                  blink_phase;
    logic                  led;
    logic [PULSE_W-1:0]    width;
    logic                  falling;

    tick_result_t          expected_results[$];
    int                    errors;

    function new();
      blink_iv    = BLINK_INTERVAL_RST;
      step_iv     = STEP_INTERVAL_RST;
      period      = PWM_PERIOD_RST;
      step_sz     = STEP_SIZE_RST;
      debounce    = DEBOUNCE_RST;
      act_low     = 1'b0;
      ramp_on     = 1'b0;
      stable      = 1'b0;
      since       = '0;
      blink_cnt   = '0;
      ramp_cnt    = '0;
      blink_phase = 1'b0;
      led         = 1'b0;
      width       = '0;
      falling     = 1'b0;
      errors      = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_BLINK_INTERVAL: blink_iv = data[INTERVAL_W-1:0];
        REG_STEP_INTERVAL:  step_iv  = data[INTERVAL_W-1:0];
        REG_PWM_PERIOD:     period   = data[PULSE_W-1:0];
        REG_STEP_SIZE:      step_sz  = data[PULSE_W-1:0];
        REG_DEBOUNCE:       debounce = data[DEBOUNCE_W-1:0];
        REG_ACTIVE_LOW:     act_low  = data[0];
        default: ;
      endcase
    endfunction

    // Saturating interval counter; an interval of 0 fires every tick like 1.
    function bit advance_timer(inout logic [INTERVAL_W-1:0] cnt,
                               input logic [INTERVAL_W-1:0] interval);
      logic [INTERVAL_W:0] nxt;
      nxt = {1'b0, cnt} + 1'b1;
      if (nxt > {1'b0, {INTERVAL_W{1'b1}}}) nxt = {1'b0, {INTERVAL_W{1'b1}}};
      if (nxt >= {1'b0, interval}) begin
        cnt = '0;
        return 1'b1;
      end
      cnt = nxt[INTERVAL_W-1:0];
      return 1'b0;
    endfunction

    // One step of the triangle: reverse and clamp at the top, and at zero.
    function void step_ramp();
      logic [PULSE_W:0] p;
      if (falling) p = (width > step_sz) ? {1'b0, width - step_sz} : '0;
      else p = {1'b0, width} + {1'b0, step_sz};
      if (p >= {1'b0, period} || p == '0) begin
        falling = ~falling;
        if (p > {1'b0, period}) p = {1'b0, period};
      end
      if (p > {1'b0, {PULSE_W{1'b1}}}) p = {1'b0, {PULSE_W{1'b1}}};
      width = p[PULSE_W-1:0];
    endfunction

    function void note_tick(bit raw);
      logic                  lvl;
      logic [DEBOUNCE_W-1:0] elapsed;
      logic                  switched;
      tick_result_t          r;
      lvl      = raw ^ act_low;
      switched = 1'b0;
      elapsed  = (since == SINCE_MAX) ? since : since + 1'b1;
      if (lvl != stable && elapsed >= debounce) begin
        stable = lvl;
        since  = '0;
        if (lvl) begin
          switched = 1'b1;
          ramp_on  = ~ramp_on;
          led      = 1'b0;
          if (ramp_on) begin
            width    = '0;
            falling  = 1'b0;
            ramp_cnt = '0;
          end else begin
            blink_cnt = '0;
          end
        end
      end else begin
        since = elapsed;
      end
      // The tick that switches mode neither blinks nor steps the ramp.
      if (!switched) begin
        if (ramp_on) begin
          if (advance_timer(ramp_cnt, step_iv)) step_ramp();
        end else if (advance_timer(blink_cnt, blink_iv)) begin
          blink_phase = ~blink_phase;
          led         = blink_phase;
        end
      end
      r.led_level    = led;
      r.pulse_width  = ramp_on ? width : '0;
      r.ramp_mode    = ramp_on;
      r.mode_changed = switched;
      expected_results.push_back(r);
    endfunction

    function void check_result(logic [M_TDATA_W-1:0] data);
      tick_result_t exp_r;
      tick_result_t got;
      got = data[M_TDATA_W-2:0];
      if (expected_results.size() == 0) begin
        $display("%0t: result %h arrived with no request outstanding", $time, data);
        errors++;
        return;
      end
      exp_r = expected_results.pop_front();
      if (got.led_level !== exp_r.led_level) begin
        $display("%0t: led_level expected %0d, got %0d", $time, exp_r.led_level,
                 got.led_level);
        errors++;
      end
      if (got.pulse_width !== exp_r.pulse_width) begin
        $display("%0t: pulse_width expected %0d, got %0d", $time, exp_r.pulse_width,
                 got.pulse_width);
        errors++;
      end
      if (got.ramp_mode !== exp_r.ramp_mode) begin
        $display("%0t: ramp_mode expected %0d, got %0d", $time, exp_r.ramp_mode,
                 got.ramp_mode);
        errors++;
      end
      if (got.mode_changed !== exp_r.mode_changed) begin
        $display("%0t: mode_changed expected %0d, got %0d", $time, exp_r.mode_changed,
                 got.mode_changed);
        errors++;
      end
      if (data[M_TDATA_W-1] !== 1'b0) begin
        $display("%0t: padding bit expected 0, got %b", $time, data[M_TDATA_W-1]);
        errors++;
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  led_blink_scoreboard   sb = new();
  int                    idle_pct = 0;
  int                    stall_pct = 0;
  int unsigned           cycle_count = 0;

  led_blink_breathe_controller_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic drive_tick(input bit raw);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(S_TDATA_W-1){1'b0}}, raw};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_tick(raw);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // Registers change only once every outstanding request has come back.
  task automatic apply_config(input phase_cfg_t c);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    write_reg(REG_SPARE_LO, '1);
    write_reg(REG_SPARE_HI, 20'h55aaa);
    write_reg(REG_BLINK_INTERVAL, CFG_DATA_W'(c.blink_iv));
    write_reg(REG_STEP_INTERVAL, CFG_DATA_W'(c.step_iv));
    write_reg(REG_PWM_PERIOD, CFG_DATA_W'(c.period));
    write_reg(REG_STEP_SIZE, CFG_DATA_W'(c.step_sz));
    write_reg(REG_DEBOUNCE, CFG_DATA_W'(c.debounce));
    write_reg(REG_ACTIVE_LOW, CFG_DATA_W'(c.act_low));
    cfg_we <= 1'b0;
  endtask

  // Mostly clean presses and releases held past the debounce time, with
  // short bounces and the odd random sample mixed in.
  task automatic run_ticks(input int n, input int unsigned deb);
    bit          lvl;
    int          hold;
    int unsigned hi;
    int unsigned lo;
    int          r;
    lvl  = 1'($urandom_range(1));
    hold = 0;
    hi   = (deb + 6 > 60) ? 60 : deb + 6;
    lo   = (deb > hi) ? hi : ((deb == 0) ? 1 : deb);
    for (int i = 0; i < n; i++) begin
      if (hold == 0) begin
        r = $urandom_range(99);
        if (r < 10) begin
          hold = 1;
          lvl  = 1'($urandom_range(1));
        end else if (r < 25) begin
          hold = $urandom_range(1, (lo > 1) ? lo - 1 : 1);
          lvl  = ~lvl;
        end else begin
          hold = $urandom_range(lo, hi);
          lvl  = ~lvl;
        end
      end
      drive_tick(lvl);
      hold--;
    end
  endtask

  initial begin
    phase_cfg_t         plan[$];
    phase_cfg_t         c;
    logic [19:0]        press_pattern;
    press_pattern = 20'b11111011111011001011;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: a press this soon after reset is held off by debounce.
    drive_tick(1'b1);
    drive_tick(1'b1);
    drive_tick(1'b0);

    // Short ramp and blink with no debounce, walking through both turns.
    c = '{blink_iv: 2, step_iv: 1, period: 6, step_sz: 4, debounce: 0, act_low: 0,
          n_ticks: 0};
    apply_config(c);
    for (int i = 19; i >= 0; i--) drive_tick(press_pattern[i]);

    plan.push_back('{3, 2, 10, 3, 2, 0, 200});
    plan.push_back('{1, 1, 7, 7, 0, 1, 150});
    plan.push_back('{0, 0, 0, 0, 1, 0, 150});
    plan.push_back('{65535, 65535, 1048575, 1048575, 1023, 1, 120});
    plan.push_back('{2, 1, 1048575, 1048575, 0, 0, 150});
    plan.push_back('{5, 3, 1048575, 1, 3, 1, 100});
    for (int i = 0; i < 6; i++) begin
      c.blink_iv = $urandom_range(1, 12);
      c.step_iv  = $urandom_range(1, 6);
      c.period   = $urandom_range(1, 40);
      c.step_sz  = $urandom_range(1, 15);
      c.debounce = $urandom_range(0, 6);
      c.act_low  = 1'($urandom_range(1));
      c.n_ticks  = 120;
      plan.push_back(c);
    end

    foreach (plan[k]) begin
      case (k % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 53; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 53; end
        default: begin idle_pct = 16; stall_pct = 16; end
      endcase
      apply_config(plan[k]);
      run_ticks(plan[k].n_ticks, plan[k].debounce);
    end

    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
